>>> design/rcr_pkg.sv
package rcr_pkg;

  localparam int PRICE_W = 20;
  localparam int REV_W   = 30;
  localparam int LEN_W   = 11;

  localparam int MAX_LEN_DEFAULT = 1024;

  // Depth of the command queue between the front and back parts.
  localparam int CMD_DEPTH = 2;

  localparam logic [PRICE_W-1:0] PRICE_CAP = PRICE_W'(1000000);
  localparam logic [REV_W-1:0]   REV_MAX   = {REV_W{1'b1}};

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] rod_length;
    logic [REV_W-1:0] revenue;
    logic             final_res;
    logic             overflow;
  } out_t;

  // Classified item as handed from the front part to the back part; the rod
  // length travels beside it because its width follows the capacity.
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last;
    logic               ovf;
  } cmd_head_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_DONE
  } back_state_t;

endpackage

>>> design/rcr_ram.sv
module rcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/rcr_queue.sv
module rcr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (rcr_pkg::CMD_DEPTH > 1) ? $clog2(rcr_pkg::CMD_DEPTH) : 1;
  localparam int NW = $clog2(rcr_pkg::CMD_DEPTH + 1);

  logic [WIDTH-1:0] mem [rcr_pkg::CMD_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == NW'(rcr_pkg::CMD_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(rcr_pkg::CMD_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(rcr_pkg::CMD_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + NW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> design/rcr_front.sv
module rcr_front #(
  parameter int MAX_LEN = rcr_pkg::MAX_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  rcr_pkg::in_t                 entry,
  output rcr_pkg::cmd_head_t           cmd_head,
  output logic [$clog2(MAX_LEN+1)-1:0] cmd_len
);

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] length_count;
  logic [CW-1:0] length_count_next;
  logic          at_capacity;

  assign at_capacity = (length_count == CW'(MAX_LEN));

  always_comb begin
    cmd_head.price = (entry.price > rcr_pkg::PRICE_CAP) ? rcr_pkg::PRICE_CAP : entry.price;
    cmd_head.last  = entry.last;
    cmd_head.ovf   = at_capacity;
    cmd_len        = at_capacity ? '0 : length_count + CW'(1);
  end

  // A last item closes the rod whether or not it was dropped.
  always_comb begin
    length_count_next = length_count;
    if (accept) begin
      if (entry.last) begin
        length_count_next = '0;
      end else if (!at_capacity) begin
        length_count_next = cmd_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_count <= '0;
    end else begin
      length_count <= length_count_next;
    end
  end

endmodule

>>> design/rcr_back.sv
module rcr_back #(
  parameter int MAX_LEN = rcr_pkg::MAX_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  rcr_pkg::cmd_head_t           cmd_head,
  input  logic [$clog2(MAX_LEN+1)-1:0] cmd_len,
  output logic                         cmd_pop,
  output rcr_pkg::out_t                res,
  output logic                         res_valid,
  input  logic                         res_taken
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  rcr_pkg::back_state_t state;
  rcr_pkg::back_state_t state_next;

  logic [CW-1:0]              cur_j;
  logic                       cur_last;
  logic                       cur_ovf;
  logic [AW-1:0]              k;
  logic [AW-1:0]              last_k;
  logic [rcr_pkg::REV_W-1:0]  best;
  logic                       rd_vld;

  logic                       price_we;
  logic                       rev_we;
  logic                       issue;
  logic                       load_res;
  logic                       out_free;

  logic [AW-1:0]              price_raddr;
  logic [AW-1:0]              rev_raddr;
  logic [rcr_pkg::PRICE_W-1:0] price_rd;
  logic [rcr_pkg::REV_W-1:0]  rev_rd;
  logic [rcr_pkg::REV_W:0]    sum;
  logic [rcr_pkg::REV_W-1:0]  cand;

  assign out_free    = !res_valid || res_taken;
  assign price_raddr = k;
  assign rev_raddr   = last_k - k;

  assign sum  = (rcr_pkg::REV_W + 1)'(price_rd) + (rcr_pkg::REV_W + 1)'(rev_rd);
  assign cand = (sum > (rcr_pkg::REV_W + 1)'(rcr_pkg::REV_MAX)) ?
                rcr_pkg::REV_MAX : sum[rcr_pkg::REV_W-1:0];

  rcr_ram #(
    .WIDTH (rcr_pkg::PRICE_W),
    .DEPTH (MAX_LEN)
  ) u_price_ram (
    .clk   (clk),
    .we    (price_we),
    .waddr (AW'(cmd_len - CW'(1))),
    .wdata (cmd_head.price),
    .raddr (price_raddr),
    .rdata (price_rd)
  );

  rcr_ram #(
    .WIDTH (rcr_pkg::REV_W),
    .DEPTH (MAX_LEN)
  ) u_rev_ram (
    .clk   (clk),
    .we    (rev_we),
    .waddr (AW'(cur_j - CW'(1))),
    .wdata (best),
    .raddr (rev_raddr),
    .rdata (rev_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      rcr_pkg::B_IDLE: begin
        if (cmd_valid) begin
          if (cmd_head.ovf || cmd_len == CW'(1)) begin
            state_next = rcr_pkg::B_DONE;
          end else begin
            state_next = rcr_pkg::B_RUN;
          end
        end
      end
      rcr_pkg::B_RUN: begin
        if (k == last_k) begin
          state_next = rcr_pkg::B_DRAIN;
        end
      end
      rcr_pkg::B_DRAIN: begin
        state_next = rcr_pkg::B_DONE;
      end
      rcr_pkg::B_DONE: begin
        if (out_free) begin
          state_next = rcr_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = rcr_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    price_we = 1'b0;
    rev_we   = 1'b0;
    issue    = 1'b0;
    load_res = 1'b0;
    case (state)
      rcr_pkg::B_IDLE: begin
        cmd_pop  = cmd_valid;
        price_we = cmd_valid && !cmd_head.ovf;
      end
      rcr_pkg::B_RUN: begin
        issue = 1'b1;
      end
      rcr_pkg::B_DRAIN: begin
        issue = 1'b0;
      end
      rcr_pkg::B_DONE: begin
        load_res = out_free;
        rev_we   = out_free && !cur_ovf;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcr_pkg::B_IDLE;
      rd_vld    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_taken) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The piece of full length needs no read: its price plus the revenue of
  // nothing, so the running best starts there.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_j    <= cmd_len;
      cur_last <= cmd_head.last;
      cur_ovf  <= cmd_head.ovf;
      k        <= '0;
      last_k   <= AW'(cmd_len - CW'(2));
      best     <= cmd_head.ovf ? '0 : rcr_pkg::REV_W'(cmd_head.price);
    end else begin
      if (issue) begin
        k <= k + AW'(1);
      end
      if (rd_vld && cand > best) begin
        best <= cand;
      end
    end
    if (load_res) begin
      res.rod_length <= cur_ovf ? '0 : rcr_pkg::LEN_W'(cur_j);
      res.revenue    <= cur_ovf ? '0 : best;
      res.final_res  <= cur_last;
      res.overflow   <= cur_ovf;
    end
  end

endmodule

>>> design/rod_cutting_revenue.sv
// Rod-cutting revenue engine. Piece prices are pushed one item at a time in
// order of piece length, the first item of a rod being the price of a piece of
// length 1; prices above 1000000 are clamped to 1000000. For each item of
// length j the block returns exactly one result item carrying j and the best
// revenue obtainable from a rod of length j, found as the maximum of the price
// of a piece of length i plus the best revenue of the remaining j-i over all i.
// An item with last set closes the rod, and its result carries final_res; the
// next item starts a new rod at length 1. Once MAX_LEN lengths have been taken
// in one rod, further items of that rod are dropped and answered with length 0,
// revenue 0 and overflow set, though a last item still closes the rod. A front
// part classifies items and passes them through a two-entry queue to a back
// part that keeps the prices and revenues in two single-port-read memories and
// walks them one entry per cycle. An item of length j passes the back part's
// idle, run, drain and done states; length 1 and dropped items skip run and
// drain. With the queue and the output register the input accepts until the
// queue is full while earlier results wait. The memories need no clearing
// after reset, as only entries written earlier in the same rod are read.
module rod_cutting_revenue #(
  parameter int MAX_LEN = rcr_pkg::MAX_LEN_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rcr_pkg::in_t  entry,
  output logic          empty,
  input  logic          pop,
  output rcr_pkg::out_t result
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int QW = $bits(rcr_pkg::cmd_head_t) + CW;

  logic               accept;
  rcr_pkg::cmd_head_t front_head;
  logic [CW-1:0]      front_len;
  logic [QW-1:0]      q_rdata;
  logic               q_empty;
  logic               cmd_pop;
  logic               res_valid;
  logic               res_taken;

  assign accept    = push && !full;
  assign empty     = !res_valid;
  assign res_taken = pop && res_valid;

  rcr_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .entry    (entry),
    .cmd_head (front_head),
    .cmd_len  (front_len)
  );

  // Each queue entry holds the classified item above its rod length.
  rcr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata ({front_head, front_len}),
    .full  (full),
    .rd    (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rcr_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd_head  (rcr_pkg::cmd_head_t'(q_rdata[QW-1:CW])),
    .cmd_len   (q_rdata[CW-1:0]),
    .cmd_pop   (cmd_pop),
    .res       (result),
    .res_valid (res_valid),
    .res_taken (res_taken)
  );

endmodule

>>> design/rcr_checker.sv
module rcr_checker (
  input logic          clk,
  input logic          rst,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input rcr_pkg::out_t result
);

  // A dropped item never reports a length or a revenue.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.overflow) |-> (result.rod_length == '0 && result.revenue == '0))
    else $error("dropped item reports a length or revenue");

  // A stored length always reports a length of at least one.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.overflow) |-> (result.rod_length != '0))
    else $error("result without overflow has length zero");

  // Reset leaves no result waiting.
  assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before it was taken");

  // The input side can only fill up when an item is pushed.
  assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("input became full without an item pushed");

endmodule

bind rod_cutting_revenue rcr_checker u_rcr_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
